// ===== hdl/bedc_pkg.sv =====
// Shared types and constants for the button edge and double-click classifier.
package bedc_pkg;

	localparam int unsigned IDX_W   = 3;
	localparam int unsigned TICK_W  = 32;
	localparam int unsigned MS_W    = 16;
	localparam int unsigned CODE_W  = 3;
	localparam int unsigned CNT_W   = 2;
	localparam int unsigned HELD_BIT = 7;
	localparam int unsigned IN_DATA_W  = 48;
	localparam int unsigned OUT_DATA_W = 8;

	typedef enum logic [CODE_W-1:0] {
		EV_NONE     = 3'd0,
		EV_PRESSED  = 3'd1,
		EV_RELEASED = 3'd2,
		EV_HELD     = 3'd3,
		EV_DOUBLE   = 3'd4
	} event_code_t;

	// per-button state entry
	typedef struct packed {
		logic              level;
		logic [CNT_W-1:0]  count;
		logic [TICK_W-1:0] first_time;
	} btn_state_t;

	// outcome of one sample against its button's entry
	typedef struct packed {
		event_code_t      code;
		logic             level;
		logic [CNT_W-1:0] count;
		logic             take_time;
	} rule_out_t;

endpackage

// ===== hdl/bedc_rule.sv =====
// Edge detection and double-click rule for one sample against one button entry.
module bedc_rule (
	input  logic                          level,
	input  logic [bedc_pkg::TICK_W-1:0]   tick_ms,
	input  logic [bedc_pkg::MS_W-1:0]     double_click_ms,
	input  bedc_pkg::btn_state_t          entry,
	output bedc_pkg::rule_out_t           result
);

	logic [bedc_pkg::TICK_W-1:0] elapsed;
	logic [bedc_pkg::TICK_W-1:0] limit;
	logic                        timed_out;
	logic                        in_window;
	logic [bedc_pkg::CNT_W-1:0]  cnt_base;

	assign elapsed   = tick_ms - entry.first_time;
	assign limit     = bedc_pkg::TICK_W'(double_click_ms);
	assign timed_out = (elapsed >= limit);
	assign in_window = (elapsed <= limit);

	always_comb begin
		result.level     = level;
		result.count     = entry.count;
		result.take_time = 1'b0;
		cnt_base         = entry.count;
		case ({entry.level, level})
			2'b01: result.code = bedc_pkg::EV_PRESSED;
			2'b10: result.code = bedc_pkg::EV_RELEASED;
			2'b11: result.code = bedc_pkg::EV_HELD;
			default: result.code = bedc_pkg::EV_NONE;
		endcase

		case (result.code)
			bedc_pkg::EV_PRESSED: begin
				// stale lone click starts over
				if (entry.count == 2'd1 && timed_out)
					cnt_base = 2'd0;
				if (cnt_base < 2'd2)
					result.count = cnt_base + 2'd1;
				else
					result.count = 2'd2;
				result.take_time = (result.count == 2'd1);
			end
			bedc_pkg::EV_RELEASED: begin
				if (entry.count == 2'd1) begin
					if (timed_out)
						result.count = 2'd0;
				end else begin
					if (entry.count == 2'd2 && in_window)
						result.code = bedc_pkg::EV_DOUBLE;
					result.count = 2'd0;
				end
			end
			default: begin
				result.count = entry.count;
			end
		endcase
	end

endmodule

// ===== hdl/button_edge_double_click_classifier_top.sv =====
// Top level of the button edge and double-click classifier.
// The input beat passes through the input register and then the result register.
// Throughput: one sample per cycle while the event stream is not stalled; the per-button
// entry is read and written in the same cycle as the result is registered, so back-to-back samples of one button chain.
// Reset clears all per-button levels, counts and first-click times at once and sets
// double_click_ms to 500; the block is ready right after reset is released.
module button_edge_double_click_classifier_top #(
	parameter int unsigned BUTTONS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                double_click_ms_we,
	input  logic [bedc_pkg::MS_W-1:0]           double_click_ms,
	// sample stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [2:0] button_index, [10:3] state_byte, [42:11] tick_ms, [47:43] zero
	input  logic [bedc_pkg::IN_DATA_W-1:0]      s_tdata,
	// event stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [2:0] event_button, [5:3] event_code, [7:6] zero
	output logic [bedc_pkg::OUT_DATA_W-1:0]     m_tdata
);

	// address width into the per-button entries
	localparam int unsigned ADDR_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
	localparam int unsigned WIDE_W = ADDR_W + bedc_pkg::IDX_W;

	logic [bedc_pkg::MS_W-1:0] dc_ms_q;

	// stage 1: registered input beat
	logic                          valid_s1;
	logic [bedc_pkg::IDX_W-1:0]    idx_s1;
	logic                          level_s1;
	logic [bedc_pkg::TICK_W-1:0]   tick_s1;

	// stage 2: result register
	logic                          valid_s2;
	logic [bedc_pkg::IDX_W-1:0]    button_s2;
	bedc_pkg::event_code_t         code_s2;

	// per-button state, cleared by reset
	bedc_pkg::btn_state_t          entry_q [BUTTONS];

	logic                          advance;
	logic                          in_range;
	logic [WIDE_W-1:0]             idx_wide;
	logic [ADDR_W-1:0]             addr;
	bedc_pkg::btn_state_t          entry_rd;
	bedc_pkg::rule_out_t           rule;
	bedc_pkg::event_code_t         code_next;

	// stage 1 moves on when the result register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	assign idx_wide = WIDE_W'(idx_s1);
	assign addr     = idx_wide[ADDR_W-1:0];
	assign in_range = (int'(idx_s1) < int'(BUTTONS));
	assign entry_rd = entry_q[addr];

	bedc_rule u_rule (
		.level           (level_s1),
		.tick_ms         (tick_s1),
		.double_click_ms (dc_ms_q),
		.entry           (entry_rd),
		.result          (rule)
	);

	// buttons beyond the table report EV_NONE and touch no state
	assign code_next = in_range ? rule.code : bedc_pkg::EV_NONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_ms_q <= bedc_pkg::MS_W'(500);
		end else if (double_click_ms_we) begin
			dc_ms_q <= double_click_ms;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			idx_s1   <= s_tdata[bedc_pkg::IDX_W-1:0];
			level_s1 <= s_tdata[bedc_pkg::IDX_W + bedc_pkg::HELD_BIT];
			tick_s1  <= s_tdata[bedc_pkg::IDX_W + 8 +: bedc_pkg::TICK_W];
		end
	end

	// per-button state update, one entry per processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(BUTTONS); i++) begin
				entry_q[i] <= '0;
			end
		end else if (advance && in_range) begin
			entry_q[addr].level <= rule.level;
			entry_q[addr].count <= rule.count;
			if (rule.take_time)
				entry_q[addr].first_time <= tick_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			button_s2 <= idx_s1;
			code_s2   <= code_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, code_s2, button_s2};

endmodule

// ===== bench/button_edge_double_click_classifier_top_tb.sv =====
// Self-checking bench for the button edge and double-click classifier top level.
`timescale 1ns / 100ps

module button_edge_double_click_classifier_top_tb;

	localparam int unsigned CLK_HALF   = 4;
	localparam int unsigned RESET_CYC  = 9;
	localparam int unsigned DRAIN_CYC  = 4;   // extra idle margin after the last event
	localparam int unsigned LONG_HOLD  = 200; // receiver hold-off in cycles
	localparam int unsigned NUM_BTN    = 8;

	localparam int unsigned IDX_W      = bedc_pkg::IDX_W;
	localparam int unsigned TICK_W     = bedc_pkg::TICK_W;
	localparam int unsigned MS_W       = bedc_pkg::MS_W;
	localparam int unsigned CNT_W      = bedc_pkg::CNT_W;
	localparam int unsigned HELD_BIT   = bedc_pkg::HELD_BIT;
	localparam int unsigned IN_DATA_W  = bedc_pkg::IN_DATA_W;
	localparam int unsigned OUT_DATA_W = bedc_pkg::OUT_DATA_W;

	// one expected event beat
	typedef struct {
		logic [IDX_W-1:0]      button;
		bedc_pkg::event_code_t code;
	} button_event_t;

	logic                  clk;
	logic                  arst_n;
	logic                  double_click_ms_we;
	logic [MS_W-1:0]       double_click_ms;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	// bench copy of the block state and its window register
	logic                  level_q [NUM_BTN];
	logic [CNT_W-1:0]      clicks_q [NUM_BTN];
	logic [TICK_W-1:0]     first_press_q [NUM_BTN];
	logic [MS_W-1:0]       window_ms;

	button_event_t         pending_events[$];
	int unsigned           err_count;
	int unsigned           samples_sent;
	logic [TICK_W-1:0]     now_ms;        // running time stamp for gesture stimulus
	bit                    gaps_on;       // random idling on both sides
	bit                    hold_req;      // ask receiver for one long hold-off

	button_edge_double_click_classifier_top dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.double_click_ms_we (double_click_ms_we),
		.double_click_ms    (double_click_ms),
		.s_tvalid           (s_tvalid),
		.s_tready           (s_tready),
		.s_tdata            (s_tdata),
		.m_tvalid           (m_tvalid),
		.m_tready           (m_tready),
		.m_tdata            (m_tdata)
	);

	always #CLK_HALF clk = ~clk;

	// ---------------------------------------------------------------------
	// Predictor: classify one sample against the button's entry and update
	// the entry. Index is 3 bits and the block has 8 buttons, so the
	// out-of-range index path cannot be hit; counts of 3 cannot be reached.
	// ---------------------------------------------------------------------
	function automatic bedc_pkg::event_code_t classify_sample(logic [IDX_W-1:0] btn,
			logic [7:0] raw, logic [TICK_W-1:0] stamp);
		logic                  lvl;
		logic                  old;
		logic [CNT_W-1:0]      cnt;
		logic [TICK_W-1:0]     elapsed;
		bedc_pkg::event_code_t code;
		lvl     = raw[HELD_BIT];
		old     = level_q[btn];
		cnt     = clicks_q[btn];
		elapsed = stamp - first_press_q[btn]; // wraps mod 2^32
		code    = bedc_pkg::EV_NONE;
		if (!old && lvl)
			code = bedc_pkg::EV_PRESSED;
		else if (old && !lvl)
			code = bedc_pkg::EV_RELEASED;
		else if (old && lvl)
			code = bedc_pkg::EV_HELD;

		if (code == bedc_pkg::EV_PRESSED) begin
			// a lone click that timed out starts over
			if (cnt == 2'd1 && elapsed >= TICK_W'(window_ms))
				cnt = 2'd0;
			cnt = (cnt < 2'd2) ? cnt + 2'd1 : 2'd2;
			if (cnt == 2'd1)
				first_press_q[btn] = stamp;
		end else if (code == bedc_pkg::EV_RELEASED) begin
			if (cnt == 2'd1) begin
				if (elapsed >= TICK_W'(window_ms))
					cnt = 2'd0;
			end else begin
				// second release inside the window is a double click
				if (cnt == 2'd2 && elapsed <= TICK_W'(window_ms))
					code = bedc_pkg::EV_DOUBLE;
				cnt = 2'd0;
			end
		end
		clicks_q[btn] = cnt;
		level_q[btn]  = lvl;
		return code;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// ---------------------------------------------------------------------
	// Sender: drive one sample beat, predict at acceptance, then maybe idle.
	// Called at a rising edge; leaves s_tvalid high when no gap follows.
	// ---------------------------------------------------------------------
	task automatic send_sample(logic [IDX_W-1:0] btn, logic [7:0] raw, logic [TICK_W-1:0] stamp);
		button_event_t ev;
		int unsigned   gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, stamp, raw, btn};
		do
			@(posedge clk);
		while (!s_tready);
		ev.button = btn;
		ev.code   = classify_sample(btn, raw, stamp);
		pending_events.push_back(ev);
		samples_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending and wait until every expected event has arrived
	task automatic drain_events();
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// window register is only written with the block idle
	task automatic write_window(logic [MS_W-1:0] value);
		drain_events();
		double_click_ms    <= value;
		double_click_ms_we <= 1'b1;
		@(posedge clk);
		double_click_ms_we <= 1'b0;
		window_ms = value;
		@(posedge clk);
	endtask

	// time step scaled to the current window so doubles land on both sides
	task automatic advance_clock();
		int unsigned r;
		int unsigned span;
		r    = $urandom_range(0, 99);
		span = int'(window_ms);
		if (r < 70)
			now_ms += $urandom_range(0, span / 3 + 1);
		else if (r < 92)
			now_ms += $urandom_range(0, span + 2);
		else
			now_ms += $urandom();
	endtask

	// one to three clicks on one button, with held beats and stray samples
	task automatic click_burst();
		logic [IDX_W-1:0] btn;
		int unsigned      presses;
		int unsigned      holds;
		btn     = IDX_W'($urandom_range(0, NUM_BTN - 1));
		presses = $urandom_range(1, 3);
		for (int unsigned p = 0; p < presses; p++) begin
			advance_clock();
			send_sample(btn, {1'b1, 7'($urandom())}, now_ms);
			holds = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
			for (int unsigned h = 0; h < holds; h++) begin
				advance_clock();
				send_sample(btn, {1'b1, 7'($urandom())}, now_ms);
			end
			// occasional stray sample from a random button in between
			if ($urandom_range(0, 9) == 0)
				send_sample(IDX_W'($urandom()), 8'($urandom()), now_ms);
			advance_clock();
			send_sample(btn, {1'b0, 7'($urandom())}, now_ms);
		end
	endtask

	// raw noise: any button, any byte, any time stamp
	task automatic noise_sample();
		send_sample(IDX_W'($urandom()), 8'($urandom()),
			($urandom_range(0, 1) == 0) ? TICK_W'($urandom()) : now_ms);
	endtask

	task automatic run_gestures(int unsigned count);
		int unsigned target;
		target = samples_sent + count;
		while (samples_sent < target) begin
			if ($urandom_range(0, 99) < 80)
				click_burst();
			else
				noise_sample();
		end
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// hand-picked sequences at the reset window of 500 ms
	task automatic test_directed_clicks();
		// button 0: press, held, release, idle low, press, release at exactly 500 ms
		send_sample(3'd0, 8'h80, 32'd1000);
		send_sample(3'd0, 8'hFF, 32'd1010);
		send_sample(3'd0, 8'h7F, 32'd1100);
		send_sample(3'd0, 8'h00, 32'd1150);
		send_sample(3'd0, 8'h80, 32'd1200);
		send_sample(3'd0, 8'h00, 32'd1500);
		// button 7: second release one ms past the window, plain release
		send_sample(3'd7, 8'h80, 32'd2000);
		send_sample(3'd7, 8'h00, 32'd2100);
		send_sample(3'd7, 8'h80, 32'd2200);
		send_sample(3'd7, 8'h7F, 32'd2501);
		// button 3: first click released at the window limit clears the count
		send_sample(3'd3, 8'h80, 32'd3000);
		send_sample(3'd3, 8'h00, 32'd3500);
		send_sample(3'd3, 8'h80, 32'd3600);
		send_sample(3'd3, 8'h00, 32'd3700);
		send_sample(3'd3, 8'h80, 32'd3900);
		send_sample(3'd3, 8'h00, 32'd4100);
		// button 5: second press after the window restarts the first click
		send_sample(3'd5, 8'h80, 32'd5000);
		send_sample(3'd5, 8'h00, 32'd5100);
		send_sample(3'd5, 8'h80, 32'd5600);
		send_sample(3'd5, 8'h00, 32'd5700);
		// button 2: double click across the time stamp wrap
		send_sample(3'd2, 8'h80, 32'hFFFF_FF00);
		send_sample(3'd2, 8'h00, 32'hFFFF_FFFF);
		send_sample(3'd2, 8'h80, 32'h0000_0000);
		send_sample(3'd2, 8'h00, 32'h0000_00F0);
		drain_events();
	endtask

	task automatic test_reset_window();
		now_ms = $urandom();
		run_gestures(350);
	endtask

	task automatic test_window_extremes();
		write_window('0);
		run_gestures(200);
		write_window('1);
		run_gestures(200);
	endtask

	task automatic test_random_windows();
		// one short window, one anywhere in range
		write_window(MS_W'($urandom_range(1, 50)));
		run_gestures(200);
		write_window(MS_W'($urandom()));
		run_gestures(200);
	endtask

	// no idling anywhere: same-button samples chain on consecutive beats
	task automatic test_back_to_back();
		write_window(16'd500);
		gaps_on = 1'b0;
		run_gestures(120);
		drain_events();
		gaps_on = 1'b1;
	endtask

	// receiver holds off while the sender keeps offering beats
	task automatic test_output_stall();
		gaps_on  = 1'b0;
		hold_req = 1'b1;
		run_gestures(60);
		drain_events();
		gaps_on = 1'b1;
	endtask

	// ---------------------------------------------------------------------
	// Receiver: random tready, plus one long hold-off on request
	// ---------------------------------------------------------------------
	initial begin
		int unsigned n;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
				m_tready <= 1'b1;
			end else if (gaps_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 3);
				repeat (n) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Event checker: each accepted beat against the oldest expectation
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		button_event_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				$error("event beat with nothing expected: tdata=%h", m_tdata);
				err_count++;
			end else begin
				want = pending_events.pop_front();
				if (m_tdata[2:0] !== want.button) begin
					$error("event_button: expected %0d, got %0d", want.button, m_tdata[2:0]);
					err_count++;
				end
				if (m_tdata[5:3] !== want.code) begin
					$error("event_code: expected %0d (%s), got %0d",
						want.code, want.code.name(), m_tdata[5:3]);
					err_count++;
				end
				if (m_tdata[7:6] !== 2'b00) begin
					$error("tdata pad: expected 0, got %0d", m_tdata[7:6]);
					err_count++;
				end
			end
		end
	end

	// run limit, far above the slowest legal run
	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		double_click_ms_we = 1'b0;
		double_click_ms    = '0;
		s_tvalid           = 1'b0;
		s_tdata            = '0;
		err_count          = 0;
		samples_sent       = 0;
		now_ms             = '0;
		gaps_on            = 1'b1;
		hold_req           = 1'b0;
		window_ms          = 16'd500;
		for (int i = 0; i < NUM_BTN; i++) begin
			level_q[i]       = 1'b0;
			clicks_q[i]      = '0;
			first_press_q[i] = '0;
		end
		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_clicks();
		test_reset_window();
		test_window_extremes();
		test_random_windows();
		test_back_to_back();
		test_output_stall();

		drain_events();
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
